// File: design/lkvc_pkg.sv
`default_nettype none

package lkvc_pkg;

   // Field widths fixed by the item format.
   localparam int DATA_W = 32;
   localparam int CAP_W  = 5;
   localparam int OPCNT_W = 32;

   // Capacity register value after reset.
   localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

   // Operation codes carried in the mode field.
   localparam logic MODE_GET = 1'b0;
   localparam logic MODE_PUT = 1'b1;

   // Sequencer states.
   typedef enum logic [2:0] {
      ST_IDLE   = 3'b001,
      ST_LOOKUP = 3'b010,
      ST_UPDATE = 3'b100
   } state_type;

   // Positions of the four operation counters.
   typedef enum logic [1:0] {
      CNT_GET_HIT  = 2'd0,
      CNT_GET_MISS = 2'd1,
      CNT_PUT_HIT  = 2'd2,
      CNT_PUT_MISS = 2'd3
   } counter_type;

   // Command broadcast from the sequencer to every cell of the row.
   typedef struct packed {
      logic lookup;      // compare key and latch match flags
      logic update;      // apply the write and the recency update
      logic promote;     // selected cell becomes most recent, others age
      logic write_data;  // selected cell takes the new value
      logic insert;      // selected cell takes the new key and turns valid
      logic use_hit;     // selection is the matching cell
      logic use_lru;     // selection is the least recent cell
      logic age_all;     // every valid cell ages, no rank limit
   } cell_cmd_type;

endpackage

`default_nettype wire

// File: design/lkvc_cell.sv
`default_nettype none

module lkvc_cell #(
   parameter int RANK_W = 4
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire lkvc_pkg::cell_cmd_type      cmd,
   input  wire logic [lkvc_pkg::DATA_W-1:0] lookup_key,
   input  wire logic [lkvc_pkg::DATA_W-1:0] write_value,
   input  wire logic [RANK_W-1:0]           lru_rank,
   input  wire logic [RANK_W-1:0]           age_limit,
   input  wire logic                        free_prev,
   output logic                             free_next,
   input  wire logic                        hit_prev,
   output logic                             hit_next,
   input  wire logic [lkvc_pkg::DATA_W-1:0] data_prev,
   output logic [lkvc_pkg::DATA_W-1:0]      data_next,
   input  wire logic [RANK_W-1:0]           rank_prev,
   output logic [RANK_W-1:0]                rank_next,
   output logic                             valid
);
   import lkvc_pkg::*;

   logic              valid_ff, valid_in;
   logic [DATA_W-1:0] key_ff, key_in;
   logic [DATA_W-1:0] data_ff, data_in;
   logic [RANK_W-1:0] rank_ff, rank_in;
   logic              hit_ff, hit_in;
   logic              lru_ff, lru_in;
   logic              free_sel;
   logic              sel;

   // The first invalid cell along the row claims a free insert.
   assign free_sel  = !valid_ff && !free_prev;
   assign free_next = free_prev || !valid_ff;

   // Only the matching cell adds its data and rank into the row.
   assign hit_next  = hit_prev || hit_ff;
   assign data_next = data_prev | (hit_ff ? data_ff : '0);
   assign rank_next = rank_prev | (hit_ff ? rank_ff : '0);

   assign valid = valid_ff;

   // Pick the cell that the current operation writes.
   always_comb begin
      if (cmd.use_hit) begin
         sel = hit_ff;
      end else if (cmd.use_lru) begin
         sel = lru_ff;
      end else begin
         sel = free_sel;
      end
   end

   // Next state of the cell.
   always_comb begin
      valid_in = valid_ff;
      key_in   = key_ff;
      data_in  = data_ff;
      rank_in  = rank_ff;
      hit_in   = hit_ff;
      lru_in   = lru_ff;
      if (cmd.lookup) begin
         hit_in = valid_ff && (key_ff == lookup_key);
         lru_in = valid_ff && (rank_ff == lru_rank);
      end
      if (cmd.update) begin
         if (sel) begin
            if (cmd.insert) begin
               valid_in = 1'b1;
               key_in   = lookup_key;
            end
            if (cmd.write_data) begin
               data_in = write_value;
            end
            if (cmd.promote) begin
               rank_in = '0;
            end
         end else if (cmd.promote && valid_ff && (cmd.age_all || (rank_ff < age_limit))) begin
            rank_in = rank_ff + 1'b1;
         end
      end
   end

   // Valid bit is the only control state of the cell.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Stored entry and match flags.
   always_ff @(posedge clock) begin
      key_ff  <= key_in;
      data_ff <= data_in;
      rank_ff <= rank_in;
      hit_ff  <= hit_in;
      lru_ff  <= lru_in;
   end

endmodule

`default_nettype wire

// File: design/lru_key_value_cache.sv
// Timing: an accepted item moves the sequencer to ST_LOOKUP and then to ST_UPDATE, and the
// result strobe is registered from ST_UPDATE.
// The cell row compares keys in ST_LOOKUP and applies the write and the recency update in
// ST_UPDATE; busy is high during the compare, and a new item can be accepted in ST_UPDATE.
// Reset clears all valid bits, the valid count and the four counters, and sets capacity to 16.
// Results cannot be stalled by the receiver.
`default_nettype none

module lru_key_value_cache #(
   parameter int ENTRIES = 16
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               start,
   output logic                                    busy,
   input  wire logic                               req_mode,
   input  wire logic signed [lkvc_pkg::DATA_W-1:0] req_lookup_key,
   input  wire logic signed [lkvc_pkg::DATA_W-1:0] req_write_value,
   output logic                                    rsp_strobe,
   output logic                                    rsp_hit,
   output logic signed [lkvc_pkg::DATA_W-1:0]      rsp_read_value,
   output logic [lkvc_pkg::OPCNT_W-1:0]            rsp_get_hit_count,
   output logic [lkvc_pkg::OPCNT_W-1:0]            rsp_get_miss_count,
   output logic [lkvc_pkg::OPCNT_W-1:0]            rsp_put_hit_count,
   output logic [lkvc_pkg::OPCNT_W-1:0]            rsp_put_miss_count,
   input  wire logic                               csr_write_enable,
   input  wire logic [lkvc_pkg::CAP_W-1:0]         csr_write_data
);
   import lkvc_pkg::*;

   localparam int RANK_W = $clog2(ENTRIES);
   localparam int CNT_W  = $clog2(ENTRIES + 1);

   state_type           state_ff, state_in;
   logic                mode_ff, mode_in;
   logic [DATA_W-1:0]   key_ff, key_in;
   logic [DATA_W-1:0]   value_ff, value_in;
   logic [CAP_W-1:0]    cap_ff, cap_in;
   logic [CNT_W-1:0]    count_ff, count_in;
   logic [OPCNT_W-1:0]  opcnt_ff [4];
   logic [OPCNT_W-1:0]  opcnt_in [4];
   logic                rsp_strobe_ff, rsp_strobe_in;
   logic                rsp_hit_ff, rsp_hit_in;
   logic [DATA_W-1:0]   rsp_read_ff, rsp_read_in;

   logic                accept;
   logic                is_put;
   logic                full;
   logic                hit_any;
   logic [CNT_W-1:0]    cap_eff;
   logic [RANK_W-1:0]   lru_rank;
   logic [RANK_W-1:0]   age_limit;
   counter_type         opcnt_sel;
   cell_cmd_type        cmd;

   logic                free_chain [ENTRIES+1];
   logic                hit_chain  [ENTRIES+1];
   logic [DATA_W-1:0]   data_chain [ENTRIES+1];
   logic [RANK_W-1:0]   rank_chain [ENTRIES+1];
   logic [ENTRIES-1:0]  valid_vec;

   // Handshake and request capture.
   assign busy   = (state_ff == ST_LOOKUP);
   assign accept = start && !busy;
   assign is_put = (mode_ff == MODE_PUT);

   always_comb begin
      mode_in  = mode_ff;
      key_in   = key_ff;
      value_in = value_ff;
      if (accept) begin
         mode_in  = req_mode;
         key_in   = $unsigned(req_lookup_key);
         value_in = $unsigned(req_write_value);
      end
   end

   // Capacity register and its clamped value.
   assign cap_in = csr_write_enable ? csr_write_data : cap_ff;

   always_comb begin
      if (cap_ff == '0) begin
         cap_eff = CNT_W'(1);
      end else if (32'(cap_ff) > ENTRIES) begin
         cap_eff = CNT_W'(ENTRIES);
      end else begin
         cap_eff = CNT_W'(cap_ff);
      end
   end

   assign full     = (count_ff >= cap_eff);
   assign lru_rank = RANK_W'(count_ff - CNT_W'(1));

   // Row results: match flag, its data and its rank.
   assign free_chain[0] = 1'b0;
   assign hit_chain[0]  = 1'b0;
   assign data_chain[0] = '0;
   assign rank_chain[0] = '0;
   assign hit_any       = hit_chain[ENTRIES];

   // Command to the cell row.
   always_comb begin
      cmd.lookup     = (state_ff == ST_LOOKUP);
      cmd.update     = (state_ff == ST_UPDATE);
      cmd.promote    = hit_any || is_put;
      cmd.write_data = is_put;
      cmd.insert     = is_put && !hit_any;
      cmd.use_hit    = hit_any;
      cmd.use_lru    = !hit_any && full;
      cmd.age_all    = !hit_any && !full;
   end

   assign age_limit = hit_any ? rank_chain[ENTRIES] : lru_rank;

   // The row of cells.
   for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
      lkvc_cell #(
         .RANK_W (RANK_W)
      ) u_cell (
         .clock       (clock),
         .reset       (reset),
         .cmd         (cmd),
         .lookup_key  (key_ff),
         .write_value (value_ff),
         .lru_rank    (lru_rank),
         .age_limit   (age_limit),
         .free_prev   (free_chain[i]),
         .free_next   (free_chain[i+1]),
         .hit_prev    (hit_chain[i]),
         .hit_next    (hit_chain[i+1]),
         .data_prev   (data_chain[i]),
         .data_next   (data_chain[i+1]),
         .rank_prev   (rank_chain[i]),
         .rank_next   (rank_chain[i+1]),
         .valid       (valid_vec[i])
      );
   end

   // Valid count grows only on an insert into a free cell.
   always_comb begin
      count_in = count_ff;
      if (cmd.update && cmd.insert && !full) begin
         count_in = count_ff + CNT_W'(1);
      end
   end

   // Saturating operation counters.
   always_comb begin
      if (is_put) begin
         opcnt_sel = hit_any ? CNT_PUT_HIT : CNT_PUT_MISS;
      end else begin
         opcnt_sel = hit_any ? CNT_GET_HIT : CNT_GET_MISS;
      end
   end

   always_comb begin
      for (int i = 0; i < 4; i++) begin
         opcnt_in[i] = opcnt_ff[i];
      end
      if (cmd.update && (opcnt_ff[opcnt_sel] != '1)) begin
         opcnt_in[opcnt_sel] = opcnt_ff[opcnt_sel] + 1'b1;
      end
   end

   // Result item.
   assign rsp_strobe_in = cmd.update;
   assign rsp_hit_in    = cmd.update ? hit_any : rsp_hit_ff;

   always_comb begin
      rsp_read_in = rsp_read_ff;
      if (cmd.update) begin
         rsp_read_in = (!is_put && hit_any) ? data_chain[ENTRIES] : '0;
      end
   end

   // Sequencer.
   always_comb begin
      case (state_ff)
         ST_IDLE: begin
            state_in = accept ? ST_LOOKUP : ST_IDLE;
         end
         ST_LOOKUP: begin
            state_in = ST_UPDATE;
         end
         ST_UPDATE: begin
            state_in = accept ? ST_LOOKUP : ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         cap_ff        <= CAP_RESET;
         count_ff      <= '0;
         rsp_strobe_ff <= 1'b0;
         for (int i = 0; i < 4; i++) begin
            opcnt_ff[i] <= '0;
         end
      end else begin
         state_ff      <= state_in;
         cap_ff        <= cap_in;
         count_ff      <= count_in;
         rsp_strobe_ff <= rsp_strobe_in;
         for (int i = 0; i < 4; i++) begin
            opcnt_ff[i] <= opcnt_in[i];
         end
      end
   end

   // Request and result payload registers.
   always_ff @(posedge clock) begin
      mode_ff     <= mode_in;
      key_ff      <= key_in;
      value_ff    <= value_in;
      rsp_hit_ff  <= rsp_hit_in;
      rsp_read_ff <= rsp_read_in;
   end

   // Output ports.
   assign rsp_strobe         = rsp_strobe_ff;
   assign rsp_hit            = rsp_hit_ff;
   assign rsp_read_value     = $signed(rsp_read_ff);
   assign rsp_get_hit_count  = opcnt_ff[CNT_GET_HIT];
   assign rsp_get_miss_count = opcnt_ff[CNT_GET_MISS];
   assign rsp_put_hit_count  = opcnt_ff[CNT_PUT_HIT];
   assign rsp_put_miss_count = opcnt_ff[CNT_PUT_MISS];

   // A result only follows an update cycle.
   a_strobe_after_update: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(state_ff == ST_UPDATE))
      else $error("result strobe without a preceding update cycle");

   // The valid count tracks the valid bits of the row.
   a_count_matches_valid: assert property (@(posedge clock) disable iff (reset)
      32'($countones(valid_vec)) == 32'(count_ff))
      else $error("valid count differs from the number of valid cells");

   // A free cell exists exactly when the row is not completely filled.
   a_free_when_not_full: assert property (@(posedge clock) disable iff (reset)
      free_chain[ENTRIES] == (32'(count_ff) < ENTRIES))
      else $error("free cell search disagrees with the valid count");

   // Misses return zero data (puts also return zero, but only misses are checked here).
   a_miss_reads_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && !rsp_hit) |-> (rsp_read_value == '0))
      else $error("nonzero read value on a miss");

   // An accepted item always enters the compare cycle.
   a_accept_to_lookup: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> (state_ff == ST_LOOKUP))
      else $error("accepted item did not start a lookup");

endmodule

`default_nettype wire

// File: tb/tb_lru_key_value_cache.sv
`default_nettype none

module tb_lru_key_value_cache;
   timeunit 1ns;
   timeprecision 1ps;

   import lkvc_pkg::*;

   localparam int ENTRIES = 16;
   localparam int CYCLE_LIMIT = 200000;
   localparam int KEY_POOL_SIZE = 24;
   localparam int SEGMENTS = 8;
   localparam int SEGMENT_ITEMS = 80;

   // One result item as the block reports it.
   typedef struct packed {
      logic                     hit;
      logic signed [DATA_W-1:0] read_value;
      logic [OPCNT_W-1:0]       get_hit_count;
      logic [OPCNT_W-1:0]       get_miss_count;
      logic [OPCNT_W-1:0]       put_hit_count;
      logic [OPCNT_W-1:0]       put_miss_count;
   } cache_result_type;

   // A row of the directed table is either an item or a capacity write.
   typedef enum logic {ROW_ITEM, ROW_CAPACITY} row_kind_type;

   typedef struct packed {
      row_kind_type      kind;
      logic              mode;
      logic [DATA_W-1:0] key;
      logic [DATA_W-1:0] value;
      logic              typed;
      logic              typed_hit;
      logic [DATA_W-1:0] typed_read;
   } directed_row_type;

   localparam int DIRECTED_COUNT = 25;

   // Extreme keys and values first, then eviction with a shrunken capacity,
   // then a saturated capacity that has room again.
   localparam directed_row_type DIRECTED_ROWS [0:DIRECTED_COUNT-1] = '{
      '{ROW_ITEM,     MODE_GET, 32'h00000000, 32'h00000000, 1'b1, 1'b0, 32'h00000000},
      '{ROW_ITEM,     MODE_PUT, 32'h80000000, 32'h7FFFFFFF, 1'b1, 1'b0, 32'h00000000},
      '{ROW_ITEM,     MODE_PUT, 32'h7FFFFFFF, 32'h80000000, 1'b1, 1'b0, 32'h00000000},
      '{ROW_ITEM,     MODE_GET, 32'h80000000, 32'h00000000, 1'b1, 1'b1, 32'h7FFFFFFF},
      '{ROW_ITEM,     MODE_GET, 32'h7FFFFFFF, 32'h00000000, 1'b1, 1'b1, 32'h80000000},
      '{ROW_ITEM,     MODE_PUT, 32'h80000000, 32'h00000000, 1'b1, 1'b1, 32'h00000000},
      '{ROW_ITEM,     MODE_GET, 32'h80000000, 32'h00000000, 1'b1, 1'b1, 32'h00000000},
      '{ROW_ITEM,     MODE_PUT, 32'hFFFFFFFF, 32'hFFFFFFFF, 1'b1, 1'b0, 32'h00000000},
      '{ROW_ITEM,     MODE_GET, 32'hFFFFFFFF, 32'h12345678, 1'b1, 1'b1, 32'hFFFFFFFF},
      '{ROW_ITEM,     MODE_PUT, 32'h00000000, 32'hA5A5A5A5, 1'b1, 1'b0, 32'h00000000},
      '{ROW_ITEM,     MODE_GET, 32'h00000000, 32'h00000000, 1'b1, 1'b1, 32'hA5A5A5A5},
      '{ROW_CAPACITY, MODE_GET, 32'h00000000, 32'h00000000, 1'b0, 1'b0, 32'h00000000},
      '{ROW_ITEM,     MODE_PUT, 32'h00000005, 32'h00000037, 1'b1, 1'b0, 32'h00000000},
      '{ROW_ITEM,     MODE_GET, 32'h7FFFFFFF, 32'h00000000, 1'b0, 1'b0, 32'h00000000},
      '{ROW_ITEM,     MODE_GET, 32'h00000005, 32'h00000000, 1'b1, 1'b1, 32'h00000037},
      '{ROW_ITEM,     MODE_PUT, 32'h00000006, 32'h00000042, 1'b0, 1'b0, 32'h00000000},
      '{ROW_ITEM,     MODE_GET, 32'h80000000, 32'h00000000, 1'b0, 1'b0, 32'h00000000},
      '{ROW_CAPACITY, MODE_GET, 32'h00000000, 32'h0000001F, 1'b0, 1'b0, 32'h00000000},
      '{ROW_ITEM,     MODE_PUT, 32'h00000007, 32'h0000004D, 1'b0, 1'b0, 32'h00000000},
      '{ROW_ITEM,     MODE_GET, 32'h00000006, 32'h00000000, 1'b0, 1'b0, 32'h00000000},
      '{ROW_CAPACITY, MODE_GET, 32'h00000000, 32'h00000010, 1'b0, 1'b0, 32'h00000000},
      '{ROW_ITEM,     MODE_PUT, 32'h00000005, 32'h7FFFFFFF, 1'b0, 1'b0, 32'h00000000},
      '{ROW_CAPACITY, MODE_GET, 32'h00000000, 32'h00000002, 1'b0, 1'b0, 32'h00000000},
      '{ROW_ITEM,     MODE_PUT, 32'h00000008, 32'h00000058, 1'b0, 1'b0, 32'h00000000},
      '{ROW_ITEM,     MODE_GET, 32'h00000008, 32'h00000000, 1'b1, 1'b1, 32'h00000058}
   };

   // Block ports.
   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     start = 1'b0;
   logic                     busy;
   logic                     req_mode = MODE_GET;
   logic signed [DATA_W-1:0] req_lookup_key = '0;
   logic signed [DATA_W-1:0] req_write_value = '0;
   logic                     rsp_strobe;
   logic                     rsp_hit;
   logic signed [DATA_W-1:0] rsp_read_value;
   logic [OPCNT_W-1:0]       rsp_get_hit_count;
   logic [OPCNT_W-1:0]       rsp_get_miss_count;
   logic [OPCNT_W-1:0]       rsp_put_hit_count;
   logic [OPCNT_W-1:0]       rsp_put_miss_count;
   logic                     csr_write_enable = 1'b0;
   logic [CAP_W-1:0]         csr_write_data = '0;

   // Shadow copy of the cache contents and counters.
   logic [CAP_W-1:0]   capacity_reg = CAP_RESET;
   bit                 slot_valid [ENTRIES];
   logic [DATA_W-1:0]  slot_key [ENTRIES];
   logic [DATA_W-1:0]  slot_data [ENTRIES];
   int unsigned        slot_age [ENTRIES];
   logic [OPCNT_W-1:0] op_count [4];

   cache_result_type   pending_results [$];
   logic [DATA_W-1:0]  key_pool [KEY_POOL_SIZE];
   int                 fail_count = 0;
   int                 cycle_count = 0;

   lru_key_value_cache #(
      .ENTRIES (ENTRIES)
   ) u_top (
      .clock              (clock),
      .reset              (reset),
      .start              (start),
      .busy               (busy),
      .req_mode           (req_mode),
      .req_lookup_key     (req_lookup_key),
      .req_write_value    (req_write_value),
      .rsp_strobe         (rsp_strobe),
      .rsp_hit            (rsp_hit),
      .rsp_read_value     (rsp_read_value),
      .rsp_get_hit_count  (rsp_get_hit_count),
      .rsp_get_miss_count (rsp_get_miss_count),
      .rsp_put_hit_count  (rsp_put_hit_count),
      .rsp_put_miss_count (rsp_put_miss_count),
      .csr_write_enable   (csr_write_enable),
      .csr_write_data     (csr_write_data)
   );

   // Clock with a 10 ns period.
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Capacity as the cache applies it: zero acts as one, large values clamp.
   function automatic int effective_capacity();
      if (capacity_reg == 0)
         return 1;
      if (capacity_reg > ENTRIES)
         return ENTRIES;
      return int'(capacity_reg);
   endfunction

   function automatic void bump_counter(counter_type which);
      if (op_count[which] != '1)
         op_count[which] = op_count[which] + 1'b1;
   endfunction

   // The chosen slot becomes most recent; valid slots younger than the limit age.
   function automatic void make_most_recent(int chosen, int unsigned limit);
      for (int i = 0; i < ENTRIES; i++)
         if (slot_valid[i] && i != chosen && slot_age[i] < limit)
            slot_age[i]++;
      slot_age[chosen] = 0;
   endfunction

   // Applies one get or put to the shadow cache and returns the result item.
   function automatic cache_result_type predict_access(logic mode, logic [DATA_W-1:0] key,
                                                       logic [DATA_W-1:0] value);
      cache_result_type res;
      int            count;
      int            chosen;
      int unsigned   oldest;
      bit            found;
      bit            any;
      res = '0;
      count = 0;
      chosen = 0;
      found = 1'b0;
      for (int i = 0; i < ENTRIES; i++) begin
         if (slot_valid[i]) begin
            count++;
            if (!found && slot_key[i] == key) begin
               found = 1'b1;
               chosen = i;
            end
         end
      end

      if (mode == MODE_GET) begin
         if (found) begin
            res.read_value = slot_data[chosen];
            make_most_recent(chosen, slot_age[chosen]);
            bump_counter(CNT_GET_HIT);
         end else begin
            bump_counter(CNT_GET_MISS);
         end
      end else if (found) begin
         slot_data[chosen] = value;
         make_most_recent(chosen, slot_age[chosen]);
         bump_counter(CNT_PUT_HIT);
      end else begin
         if (count >= effective_capacity()) begin
            // Full: replace the least recently used valid slot.
            oldest = 0;
            any = 1'b0;
            for (int i = 0; i < ENTRIES; i++) begin
               if (slot_valid[i] && (!any || slot_age[i] > oldest)) begin
                  oldest = slot_age[i];
                  chosen = i;
                  any = 1'b1;
               end
            end
            make_most_recent(chosen, oldest);
         end else begin
            // Room left: take the lowest-numbered free slot.
            for (int i = ENTRIES - 1; i >= 0; i--)
               if (!slot_valid[i])
                  chosen = i;
            make_most_recent(chosen, 32'hFFFF_FFFF);
         end
         slot_valid[chosen] = 1'b1;
         slot_key[chosen] = key;
         slot_data[chosen] = value;
         bump_counter(CNT_PUT_MISS);
      end

      res.hit = found;
      res.get_hit_count = op_count[CNT_GET_HIT];
      res.get_miss_count = op_count[CNT_GET_MISS];
      res.put_hit_count = op_count[CNT_PUT_HIT];
      res.put_miss_count = op_count[CNT_PUT_MISS];
      return res;
   endfunction

   function automatic void check_field(string name, logic [DATA_W-1:0] want,
                                       logic [DATA_W-1:0] got);
      if (got !== want) begin
         $error("%s: expected %h, got %h", name, want, got);
         fail_count++;
      end
   endfunction

   // Presents one item, waits until the cache takes it and records its result.
   task automatic issue_item(input logic mode, input logic [DATA_W-1:0] key,
                             input logic [DATA_W-1:0] value, input int idle_pct,
                             input logic typed, input logic typed_hit,
                             input logic [DATA_W-1:0] typed_read);
      cache_result_type want;
      if ($urandom_range(0, 99) < idle_pct) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_mode <= mode;
      req_lookup_key <= key;
      req_write_value <= value;
      start <= 1'b1;
      @(posedge clock);
      while (busy)
         @(posedge clock);
      want = predict_access(mode, key, value);
      if (typed) begin
         want.hit = typed_hit;
         want.read_value = typed_read;
      end
      pending_results.push_back(want);
   endtask

   // Stops issuing and waits until every outstanding result has come back.
   task automatic drain_results();
      start <= 1'b0;
      while (pending_results.size() != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_capacity(input logic [CAP_W-1:0] value);
      drain_results();
      csr_write_data <= value;
      csr_write_enable <= 1'b1;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      capacity_reg = value;
   endtask

   // Result checker: every strobe must match the oldest waiting item.
   always @(posedge clock) begin
      cache_result_type want;
      if (!reset && rsp_strobe) begin
         if (pending_results.size() == 0) begin
            $error("result arrived with no item outstanding");
            fail_count++;
         end else begin
            want = pending_results.pop_front();
            check_field("hit", want.hit, rsp_hit);
            check_field("read_value", want.read_value, rsp_read_value);
            check_field("get_hit_count", want.get_hit_count, rsp_get_hit_count);
            check_field("get_miss_count", want.get_miss_count, rsp_get_miss_count);
            check_field("put_hit_count", want.put_hit_count, rsp_put_hit_count);
            check_field("put_miss_count", want.put_miss_count, rsp_put_miss_count);
         end
      end
   end

   // Watchdog.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   // Stimulus.
   initial begin
      logic [CAP_W-1:0]  segment_caps [SEGMENTS];
      logic [DATA_W-1:0] key;
      logic              mode;
      int                idle_pct;
      int                span;

      segment_caps = '{5'd16, 5'd3, 5'd1, 5'd31, 5'd0, 5'd8, 5'd17, 5'd16};
      key_pool[0] = 32'h0000_0000;
      key_pool[1] = 32'h8000_0000;
      key_pool[2] = 32'h7FFF_FFFF;
      key_pool[3] = 32'hFFFF_FFFF;
      for (int i = 4; i < KEY_POOL_SIZE; i++)
         key_pool[i] = $urandom;
      for (int i = 0; i < ENTRIES; i++) begin
         slot_valid[i] = 1'b0;
         slot_key[i] = '0;
         slot_data[i] = '0;
         slot_age[i] = 0;
      end
      for (int i = 0; i < 4; i++)
         op_count[i] = '0;

      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed table.
      for (int r = 0; r < DIRECTED_COUNT; r++) begin
         if (DIRECTED_ROWS[r].kind == ROW_CAPACITY)
            write_capacity(DIRECTED_ROWS[r].value[CAP_W-1:0]);
         else
            issue_item(DIRECTED_ROWS[r].mode, DIRECTED_ROWS[r].key,
                       DIRECTED_ROWS[r].value, 0, DIRECTED_ROWS[r].typed,
                       DIRECTED_ROWS[r].typed_hit, DIRECTED_ROWS[r].typed_read);
      end

      // Random segments: light sender gaps, then heavy gaps, then back to back.
      for (int seg = 0; seg < SEGMENTS; seg++) begin
         write_capacity(segment_caps[seg]);
         idle_pct = (seg < 3) ? 21 : ((seg < 6) ? 88 : 0);
         span = effective_capacity() + 4;
         if (span > KEY_POOL_SIZE)
            span = KEY_POOL_SIZE;
         for (int n = 0; n < SEGMENT_ITEMS; n++) begin
            // Mostly keys from a pool a little larger than the capacity, so
            // hits, updates and evictions all happen; now and then a fresh key.
            if ($urandom_range(0, 9) == 0)
               key = $urandom;
            else
               key = key_pool[$urandom_range(0, span - 1)];
            mode = $urandom_range(0, 1) ? MODE_PUT : MODE_GET;
            issue_item(mode, key, $urandom, idle_pct, 1'b0, 1'b0, '0);
         end
      end

      drain_results();
      repeat (4) @(posedge clock);
      if (fail_count == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

endmodule

`default_nettype wire
